/* rtl/core/hnm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared types and constants for the binary descriptor nearest match block.
// ----------------------------------------------------------------------------
package hnm_pkg;

  localparam int QUERY_BITS = 256;
  localparam int WORD_BITS  = 64;
  localparam int DIST_W     = 9;
  localparam int IDX_W      = 12;
  localparam int LVL_IN_W   = 3;
  localparam int LVL_W      = 4;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;

  localparam int MAX_FEATURES_DEF = 4096;
  localparam int NUM_LEVELS_DEF   = 8;

  localparam logic [DIST_W-1:0] DIST_NONE      = 9'd256;
  localparam logic [LVL_W-1:0]  LVL_NONE       = 4'hF;
  localparam logic [DIST_W-1:0] THRESHOLD_RST  = 9'd50;
  localparam logic [DIST_W-1:0] RATIO_RST      = 9'd154;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 3'd6;

  // acceptance modes
  localparam logic [MODE_W-1:0] MODE_RATIO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEVEL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd2;

  typedef struct packed {
    logic [WORD_BITS-1:0] cand_word0;
    logic [WORD_BITS-1:0] cand_word1;
    logic [WORD_BITS-1:0] cand_word2;
    logic [WORD_BITS-1:0] cand_word3;
    logic [IDX_W-1:0]     cand_index;
    logic [LVL_IN_W-1:0]  cand_level;
    logic                 skip;
    logic                 last;
  } cand_word_t;

  typedef struct packed {
    logic              match_found;
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] best_distance;
    logic [DIST_W-1:0] second_distance;
  } res_word_t;

endpackage

/* rtl/core/hnm_popcnt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnm_popcnt
// Population count of a 256-bit word through a byte count and adder tree.
// ----------------------------------------------------------------------------
module hnm_popcnt (
  input  logic [hnm_pkg::QUERY_BITS-1:0] bits,
  output logic [hnm_pkg::DIST_W-1:0]     count
);
  import hnm_pkg::*;

  localparam int NBYTES = QUERY_BITS / 8;

  logic [3:0] lv0 [NBYTES];
  logic [4:0] lv1 [NBYTES/2];
  logic [5:0] lv2 [NBYTES/4];
  logic [6:0] lv3 [NBYTES/8];
  logic [7:0] lv4 [NBYTES/16];

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] c;
    c = 4'd0;
    for (int k = 0; k < 8; k++) begin
      c = c + {3'd0, b[k]};
    end
    return c;
  endfunction

  always_comb begin
    for (int i = 0; i < NBYTES; i++) begin
      lv0[i] = pop8(bits[8*i +: 8]);
    end
    for (int i = 0; i < NBYTES/2; i++) begin
      lv1[i] = {1'b0, lv0[2*i]} + {1'b0, lv0[2*i+1]};
    end
    for (int i = 0; i < NBYTES/4; i++) begin
      lv2[i] = {1'b0, lv1[2*i]} + {1'b0, lv1[2*i+1]};
    end
    for (int i = 0; i < NBYTES/8; i++) begin
      lv3[i] = {1'b0, lv2[2*i]} + {1'b0, lv2[2*i+1]};
    end
    for (int i = 0; i < NBYTES/16; i++) begin
      lv4[i] = {1'b0, lv3[2*i]} + {1'b0, lv3[2*i+1]};
    end
    count = {1'b0, lv4[0]} + {1'b0, lv4[1]};
  end

endmodule

/* rtl/core/hamming_nearest_match_ratio_test_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_nearest_match_ratio_test_top
// Nearest and second nearest Hamming match of a candidate stream against a
// configured 256-bit query; threshold and per-mode ratio test at run end.
// ----------------------------------------------------------------------------
// result path: the decision for a run passes the input reg, distance reg, run
//   snapshot reg and result reg before it appears on res_valid
// throughput: one candidate word per cycle; a waiting result blocks a
//   following last word, and the words behind that last word stall with it
// reset: rst clears the pipeline, the running best/second state and the
//   registers to their defaults (threshold 50, ratio 154, mode 0, query 0)
module hamming_nearest_match_ratio_test_top #(
  parameter int MAX_FEATURES = hnm_pkg::MAX_FEATURES_DEF,
  parameter int NUM_LEVELS   = hnm_pkg::NUM_LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cand_valid,
  output logic                          cand_stall,
  input  hnm_pkg::cand_word_t           cand,
  output logic                          res_valid,
  input  logic                          res_stall,
  output hnm_pkg::res_word_t            res,
  input  logic                          cfg_we,
  input  logic [hnm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hnm_pkg::WORD_BITS-1:0] cfg_data
);
  import hnm_pkg::*;

  // configuration
  logic [QUERY_BITS-1:0] query;
  logic [MODE_W-1:0]     accept_mode;
  logic [DIST_W-1:0]     dist_threshold;
  logic [DIST_W-1:0]     ratio_q8;

  always_ff @(posedge clk) begin
    if (rst) begin
      query          <= '0;
      accept_mode    <= MODE_RATIO;
      dist_threshold <= THRESHOLD_RST;
      ratio_q8       <= RATIO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUERY0:    query[0*WORD_BITS +: WORD_BITS] <= cfg_data;
        CFG_QUERY1:    query[1*WORD_BITS +: WORD_BITS] <= cfg_data;
        CFG_QUERY2:    query[2*WORD_BITS +: WORD_BITS] <= cfg_data;
        CFG_QUERY3:    query[3*WORD_BITS +: WORD_BITS] <= cfg_data;
        CFG_MODE:      accept_mode    <= cfg_data[MODE_W-1:0];
        CFG_THRESHOLD: dist_threshold <= cfg_data[DIST_W-1:0];
        CFG_RATIO:     ratio_q8       <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  logic s1_valid, s2_valid, s3_valid;
  logic out_move, s3_adv, s3_free, s2_adv, s2_free, s1_adv, s1_free;
  logic s2_last;

  assign out_move   = !res_valid || !res_stall;
  assign s3_adv     = s3_valid && out_move;
  assign s3_free    = !s3_valid || out_move;
  assign s2_adv     = s2_valid && (!s2_last || s3_free);
  assign s2_free    = !s2_valid || s2_adv;
  assign s1_adv     = s1_valid && s2_free;
  assign s1_free    = !s1_valid || s1_adv;
  assign cand_stall = !s1_free;

  // stage 1: input register
  cand_word_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= cand_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && cand_valid) begin
      s1 <= cand;
    end
  end

  // stage 2: distance register
  logic [QUERY_BITS-1:0] diff;
  logic [DIST_W-1:0]     ham_dist;
  logic                  s1_ok;
  logic [DIST_W-1:0]     s2_dist;
  logic [IDX_W-1:0]      s2_idx;
  logic [LVL_W-1:0]      s2_lvl;
  logic                  s2_ok;

  assign diff = query ^ {s1.cand_word3, s1.cand_word2, s1.cand_word1, s1.cand_word0};
  assign s1_ok = !s1.skip && (32'(s1.cand_index) < 32'(MAX_FEATURES))
              && (32'(s1.cand_level) < 32'(NUM_LEVELS));

  hnm_popcnt u_popcnt (
    .bits  (diff),
    .count (ham_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_dist <= ham_dist;
      s2_idx  <= s1.cand_index;
      s2_lvl  <= {1'b0, s1.cand_level};
      s2_ok   <= s1_ok;
      s2_last <= s1.last;
    end
  end

  // running best and second
  logic [DIST_W-1:0] best_dist, second_dist;
  logic [IDX_W-1:0]  best_idx;
  logic [LVL_W-1:0]  best_lvl, second_lvl;
  logic [DIST_W-1:0] upd_best_dist, upd_second_dist;
  logic [IDX_W-1:0]  upd_best_idx;
  logic [LVL_W-1:0]  upd_best_lvl, upd_second_lvl;
  logic [DIST_W-1:0] best_dist_next, second_dist_next;
  logic [IDX_W-1:0]  best_idx_next;
  logic [LVL_W-1:0]  best_lvl_next, second_lvl_next;

  always_comb begin
    upd_best_dist   = best_dist;
    upd_second_dist = second_dist;
    upd_best_idx    = best_idx;
    upd_best_lvl    = best_lvl;
    upd_second_lvl  = second_lvl;
    if (s2_ok) begin
      if (s2_dist < best_dist) begin
        upd_second_dist = best_dist;
        upd_second_lvl  = best_lvl;
        upd_best_dist   = s2_dist;
        upd_best_lvl    = s2_lvl;
        upd_best_idx    = s2_idx;
      end else if (s2_dist < second_dist) begin
        upd_second_dist = s2_dist;
        upd_second_lvl  = s2_lvl;
      end
    end
    best_dist_next   = best_dist;
    second_dist_next = second_dist;
    best_idx_next    = best_idx;
    best_lvl_next    = best_lvl;
    second_lvl_next  = second_lvl;
    if (s2_adv) begin
      if (s2_last) begin
        best_dist_next   = DIST_NONE;
        second_dist_next = DIST_NONE;
        best_idx_next    = '0;
        best_lvl_next    = LVL_NONE;
        second_lvl_next  = LVL_NONE;
      end else begin
        best_dist_next   = upd_best_dist;
        second_dist_next = upd_second_dist;
        best_idx_next    = upd_best_idx;
        best_lvl_next    = upd_best_lvl;
        second_lvl_next  = upd_second_lvl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_dist   <= DIST_NONE;
      second_dist <= DIST_NONE;
      best_idx    <= '0;
      best_lvl    <= LVL_NONE;
      second_lvl  <= LVL_NONE;
    end else begin
      best_dist   <= best_dist_next;
      second_dist <= second_dist_next;
      best_idx    <= best_idx_next;
      best_lvl    <= best_lvl_next;
      second_lvl  <= second_lvl_next;
    end
  end

  // stage 3: final snapshot of a run
  logic [DIST_W-1:0] s3_best_dist, s3_second_dist;
  logic [IDX_W-1:0]  s3_best_idx;
  logic              s3_lvl_eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && s2_valid && s2_last) begin
      s3_best_dist   <= upd_best_dist;
      s3_second_dist <= upd_second_dist;
      s3_best_idx    <= upd_best_idx;
      s3_lvl_eq      <= (upd_best_lvl == upd_second_lvl);
    end
  end

  // decision
  logic [2*DIST_W-1:0] lhs, rhs;
  logic                found;

  assign lhs = {1'b0, s3_best_dist, 8'd0};
  assign rhs = ratio_q8 * s3_second_dist;

  always_comb begin
    found = 1'b0;
    if (s3_best_dist < DIST_NONE && s3_best_dist <= dist_threshold) begin
      case (accept_mode)
        MODE_RATIO: found = lhs < rhs;
        MODE_LEVEL: found = !(s3_lvl_eq && lhs > rhs);
        default:    found = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_move) begin
      res_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      res.match_found     <= found;
      res.best_index      <= s3_best_idx;
      res.best_distance   <= s3_best_dist;
      res.second_distance <= s3_second_dist;
    end
  end

  // checks
  ast_order: assert property (@(posedge clk) disable iff (rst)
    best_dist <= second_dist)
    else $error("best distance above second distance");

  ast_clear: assert property (@(posedge clk) disable iff (rst)
    s2_adv && s2_last |=> best_dist == DIST_NONE && second_dist == DIST_NONE
                          && best_lvl == LVL_NONE)
    else $error("running state not cleared after end of run");

  ast_no_best_lvl: assert property (@(posedge clk) disable iff (rst)
    best_dist == DIST_NONE |-> best_lvl == LVL_NONE && best_idx == '0)
    else $error("level or index held without a best candidate");

  ast_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.match_found |-> res.best_distance != DIST_NONE)
    else $error("match reported for empty run");

endmodule

/* dv/hamming_nearest_match_ratio_test_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_nearest_match_ratio_test_checker
// Passive monitor for the nearest match block. It tracks register writes,
// folds every accepted, unskipped, in-range candidate word into its own
// best and second best state, queues a decision per run end and compares
// each accepted result word to the oldest queued decision, field by field.
// ----------------------------------------------------------------------------
module hamming_nearest_match_ratio_test_checker #(
  parameter int MAX_FEATURES = hnm_pkg::MAX_FEATURES_DEF,
  parameter int NUM_LEVELS   = hnm_pkg::NUM_LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cand_valid,
  input  logic                          cand_stall,
  input  hnm_pkg::cand_word_t           cand,
  input  logic                          res_valid,
  input  logic                          res_stall,
  input  hnm_pkg::res_word_t            res,
  input  logic                          cfg_we,
  input  logic [hnm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hnm_pkg::WORD_BITS-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import hnm_pkg::*;

  logic [QUERY_BITS-1:0] query;
  logic [MODE_W-1:0]     mode;
  logic [DIST_W-1:0]     threshold;
  logic [DIST_W-1:0]     ratio;

  logic [DIST_W-1:0]     best_dist;
  logic [DIST_W-1:0]     second_dist;
  logic [IDX_W-1:0]      best_idx;
  logic [LVL_W-1:0]      best_lvl;
  logic [LVL_W-1:0]      second_lvl;

  res_word_t             decisions_q[$];

  task automatic clear_run();
    best_dist   = DIST_NONE;
    second_dist = DIST_NONE;
    best_idx    = '0;
    best_lvl    = LVL_NONE;
    second_lvl  = LVL_NONE;
  endtask

  always @(posedge clk) begin : watch
    res_word_t         exp_res;
    logic [DIST_W-1:0] ham_dist;
    logic [17:0]       lhs;
    logic [17:0]       rhs;
    logic              ok;
    logic              ignore;
    int                errs;
    errs = 0;
    if (rst) begin
      query     = '0;
      mode      = MODE_RATIO;
      threshold = THRESHOLD_RST;
      ratio     = RATIO_RST;
      clear_run();
      decisions_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUERY0:    query[63:0]    = cfg_data;
          CFG_QUERY1:    query[127:64]  = cfg_data;
          CFG_QUERY2:    query[191:128] = cfg_data;
          CFG_QUERY3:    query[255:192] = cfg_data;
          CFG_MODE:      mode           = cfg_data[MODE_W-1:0];
          CFG_THRESHOLD: threshold      = cfg_data[DIST_W-1:0];
          CFG_RATIO:     ratio          = cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end

      if (res_valid && !res_stall) begin
        if (decisions_q.size() == 0) begin
          $error("result word with no decision waiting");
          errs++;
        end else begin
          exp_res = decisions_q.pop_front();
          if (res.match_found !== exp_res.match_found) begin
            $error("match_found: expected %0d, got %0d", exp_res.match_found, res.match_found);
            errs++;
          end
          if (res.best_index !== exp_res.best_index) begin
            $error("best_index: expected %0d, got %0d", exp_res.best_index, res.best_index);
            errs++;
          end
          if (res.best_distance !== exp_res.best_distance) begin
            $error("best_distance: expected %0d, got %0d",
                   exp_res.best_distance, res.best_distance);
            errs++;
          end
          if (res.second_distance !== exp_res.second_distance) begin
            $error("second_distance: expected %0d, got %0d",
                   exp_res.second_distance, res.second_distance);
            errs++;
          end
        end
      end

      if (cand_valid && !cand_stall) begin
        ignore = cand.skip || (cand.cand_index >= MAX_FEATURES) ||
                 (cand.cand_level >= NUM_LEVELS);
        ham_dist = DIST_W'($countones(query ^ {cand.cand_word3, cand.cand_word2,
                                               cand.cand_word1, cand.cand_word0}));
        if (!ignore) begin
          if (ham_dist < best_dist) begin
            second_dist = best_dist;
            second_lvl  = best_lvl;
            best_dist   = ham_dist;
            best_lvl    = {1'b0, cand.cand_level};
            best_idx    = cand.cand_index;
          end else if (ham_dist < second_dist) begin
            second_dist = ham_dist;
            second_lvl  = {1'b0, cand.cand_level};
          end
        end
        if (cand.last) begin
          // exact integer form of best / second against the q1.8 ratio
          lhs = {1'b0, best_dist, 8'd0};
          rhs = ratio * second_dist;
          ok = 1'b0;
          if (best_dist < DIST_NONE && best_dist <= threshold) begin
            if (mode == MODE_RATIO) begin
              ok = lhs < rhs;
            end else if (mode == MODE_LEVEL) begin
              ok = !(best_lvl == second_lvl && lhs > rhs);
            end else begin
              ok = 1'b1;
            end
          end
          exp_res.match_found     = ok;
          exp_res.best_index      = best_idx;
          exp_res.best_distance   = best_dist;
          exp_res.second_distance = second_dist;
          decisions_q.insert(decisions_q.size(), exp_res);
          clear_run();
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= decisions_q.size();
  end

endmodule

/* dv/hamming_nearest_match_ratio_test_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_nearest_match_ratio_test_top_tb
// Stimulus and verdict for the nearest match block. A directed pass covers
// empty runs, ties, unreachable distances, skipped run ends and every mode,
// three at edge register values; then random phases, each under a fresh
// setting, stream candidate runs near the query mixed with noise, random gaps
// and result stalls. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module hamming_nearest_match_ratio_test_top_tb;
  import hnm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 130;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cand_valid = 1'b0;
  logic                  cand_stall;
  cand_word_t            cand = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  res_word_t             res;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [WORD_BITS-1:0]  cfg_data = '0;
  int                    fail_count;
  int                    pending;
  int                    cycles = 0;
  int                    hold_left = 0;
  logic                  burst = 1'b0;
  logic [QUERY_BITS-1:0] query_bits = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hamming_nearest_match_ratio_test_top dut (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .cand       (cand),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  hamming_nearest_match_ratio_test_checker match_check (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .cand       (cand),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int draw_wait();
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  // result side: a stall drawn after each taken word, counted down while a word waits
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left = 0;
    end else if (res_valid && !res_stall) begin
      hold_left = draw_wait();
      res_stall <= (hold_left != 0);
    end else if (res_valid && hold_left != 0) begin
      hold_left = hold_left - 1;
      res_stall <= (hold_left != 0);
    end
  end

  function automatic logic [QUERY_BITS-1:0] rand256();
    logic [QUERY_BITS-1:0] v;
    for (int i = 0; i < QUERY_BITS / 32; i++) begin
      v[i*32 +: 32] = $urandom;
    end
    return v;
  endfunction

  function automatic cand_word_t build(logic [QUERY_BITS-1:0] bits, logic [IDX_W-1:0] idx,
                                       logic [LVL_IN_W-1:0] lvl, logic skp, logic lst);
    cand_word_t c;
    c.cand_word0 = bits[63:0];
    c.cand_word1 = bits[127:64];
    c.cand_word2 = bits[191:128];
    c.cand_word3 = bits[255:192];
    c.cand_index = idx;
    c.cand_level = lvl;
    c.skip       = skp;
    c.last       = lst;
    return c;
  endfunction

  // candidate exactly n bits away from the query
  function automatic cand_word_t cand_at(int n, logic [IDX_W-1:0] idx,
                                         logic [LVL_IN_W-1:0] lvl, logic skp, logic lst);
    logic [QUERY_BITS-1:0] mask;
    mask = '0;
    for (int b = 0; b < n && b < QUERY_BITS; b++) begin
      mask[b] = 1'b1;
    end
    return build(query_bits ^ mask, idx, lvl, skp, lst);
  endfunction

  // candidate at most k bits away from the query
  function automatic logic [QUERY_BITS-1:0] near_word(int k);
    logic [QUERY_BITS-1:0] mask;
    int pos;
    mask = '0;
    repeat (k) begin
      pos = $urandom_range(0, QUERY_BITS - 1);
      mask[pos] = ~mask[pos];
    end
    return query_bits ^ mask;
  endfunction

  task automatic send(cand_word_t w);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      cand_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cand_valid <= 1'b1;
    cand       <= w;
    do @(posedge clk); while (cand_stall);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(logic [QUERY_BITS-1:0] q, logic [MODE_W-1:0] mode,
                              logic [DIST_W-1:0] thr, logic [DIST_W-1:0] ratio);
    logic [WORD_BITS-1:0] junk;
    junk = {$urandom, $urandom};
    query_bits = q;
    put_reg(CFG_QUERY0, q[63:0]);
    put_reg(CFG_QUERY1, q[127:64]);
    put_reg(CFG_QUERY2, q[191:128]);
    put_reg(CFG_QUERY3, q[255:192]);
    // upper bits beyond each register's width carry noise
    put_reg(CFG_MODE, {junk[WORD_BITS-1:MODE_W], mode});
    put_reg(CFG_THRESHOLD, {junk[WORD_BITS-1:DIST_W], thr});
    put_reg(CFG_RATIO, {~junk[WORD_BITS-1:DIST_W], ratio});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every decision has come, then let the pipeline drain
  task automatic settle();
    cand_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [QUERY_BITS-1:0] word;
    logic [QUERY_BITS-1:0] prev_word;
    logic [31:0]           r;
    logic [MODE_W-1:0]     mode;
    logic [DIST_W-1:0]     thr;
    logic [DIST_W-1:0]     ratio;
    int                    sent;
    int                    len;
    prev_word = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset setting: query zero, threshold 50, ratio 154, plain ratio test
    send(cand_at(0, 12'd0, 3'd0, 1'b1, 1'b1));
    send(cand_at(0, 12'd4095, 3'd7, 1'b0, 1'b1));
    send(cand_at(256, 12'd1, 3'd0, 1'b0, 1'b0));
    send(cand_at(256, 12'd2, 3'd0, 1'b0, 1'b1));
    send(cand_at(10, 12'd5, 3'd3, 1'b0, 1'b0));
    send(cand_at(10, 12'd7, 3'd3, 1'b0, 1'b0));
    send(cand_at(20, 12'd9, 3'd3, 1'b1, 1'b1));
    send(cand_at(40, 12'd11, 3'd1, 1'b0, 1'b0));
    send(cand_at(30, 12'd12, 3'd2, 1'b0, 1'b1));
    send(cand_at(51, 12'd13, 3'd4, 1'b0, 1'b1));
    send(cand_at(0, 12'd14, 3'd5, 1'b0, 1'b0));
    send(cand_at(0, 12'd15, 3'd6, 1'b0, 1'b1));
    settle();

    apply_config(rand256(), MODE_LEVEL, 9'd256, 9'd256);
    send(cand_at(100, 12'd1, 3'd2, 1'b0, 1'b0));
    send(cand_at(100, 12'd2, 3'd2, 1'b0, 1'b1));
    send(cand_at(100, 12'd1, 3'd2, 1'b0, 1'b0));
    send(cand_at(110, 12'd2, 3'd3, 1'b0, 1'b1));
    send(cand_at(255, 12'd3, 3'd0, 1'b0, 1'b1));
    settle();

    apply_config(rand256(), MODE_NONE, 9'd0, 9'd0);
    send(cand_at(0, 12'd2730, 3'd5, 1'b0, 1'b1));
    send(cand_at(1, 12'd1365, 3'd2, 1'b0, 1'b1));
    settle();

    apply_config(rand256(), MODE_UNUSED, 9'd511, 9'd511);
    send(cand_at(200, 12'd100, 3'd1, 1'b0, 1'b0));
    send(cand_at(256, 12'd101, 3'd1, 1'b0, 1'b0));
    send(cand_at(255, 12'd102, 3'd1, 1'b0, 1'b1));

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      r = $urandom;
      case (ph % 4)
        0:       mode = MODE_RATIO;
        1:       mode = MODE_LEVEL;
        2:       mode = MODE_NONE;
        default: mode = MODE_UNUSED;
      endcase
      case ($urandom_range(0, 4))
        0:       thr = THRESHOLD_RST;
        1:       thr = 9'd256;
        2:       thr = '1;
        3:       thr = r[8:0];
        default: thr = {2'b00, r[15:9]};
      endcase
      case ($urandom_range(0, 4))
        0:       ratio = RATIO_RST;
        1:       ratio = 9'd256;
        2:       ratio = '1;
        3:       ratio = '0;
        default: ratio = r[24:16];
      endcase
      apply_config(rand256(), mode, thr, ratio);

      sent = 0;
      while (sent < PHASE_WORDS) begin
        burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 15) == 0) begin
          // noise: unrelated words, run ends at random
          repeat ($urandom_range(1, 4)) begin
            r = $urandom;
            send(build(rand256(), r[11:0], r[14:12], r[15], r[16]));
            sent++;
          end
        end else begin
          len = $urandom_range(1, 10);
          for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
              6:       word = rand256();
              7:       word = ~query_bits;
              8:       word = prev_word;
              9:       word = near_word($urandom_range(80, 256));
              default: word = near_word($urandom_range(0, 80));
            endcase
            prev_word = word;
            r = $urandom;
            send(build(word, r[11:0], r[12] ? {2'b00, r[13]} : r[15:13],
                       r[18:16] == 3'd0, i == len - 1));
            sent++;
          end
        end
      end
    end
    burst = 1'b0;

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
